@@ design/pgrr_pkg.sv @@
// Package for the proportional glyph row renderer: beat types, function and
// register codes, sequencer states and the row mask helper.
// No dependencies.
`timescale 1ns / 1ps

package pgrr_pkg;

  // The glyph store address is twelve bits wide on the input, so its depth is fixed.
  localparam int GLYPH_BYTES = 4096;
  localparam int GLYPH_AW = $clog2(GLYPH_BYTES);
  localparam int CHAR_SLOTS_DEF = 128;
  localparam int MAX_WIDTH = 32;
  localparam int MAX_HEIGHT = 32;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [9:0] PEN_MAX = 10'd1023;

  typedef enum logic [2:0] {
    FN_LOAD_CHAR = 3'd0,
    FN_LOAD_BYTE = 3'd1,
    FN_SET_X     = 3'd2,
    FN_RENDER    = 3'd3,
    FN_MEASURE   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    CFG_GLYPH_HEIGHT = 2'd0,
    CFG_FIRST_CODE   = 2'd1,
    CFG_GAP_WIDTH    = 2'd2,
    CFG_BLANK_WIDTH  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ROWS,
    ST_SINGLE
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  char_code;
    logic [11:0] table_index;
    logic [5:0]  entry_width;
    logic [11:0] entry_offset;
    logic [7:0]  glyph_byte;
    logic [9:0]  start_x;
  } in_item_t;

  typedef struct packed {
    logic [31:0] row_bits;
    logic [5:0]  row_width;
    logic        row_last;
    logic [9:0]  pen_x;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  width;
    logic [11:0] offset;
  } tbl_entry_t;

  // Keeps the leftmost w pixels of a row.
  function automatic logic [31:0] row_mask(logic [5:0] w);
    return ~(32'hFFFF_FFFF >> w);
  endfunction

endpackage

@@ design/pgrr_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the character table and the glyph store.
`timescale 1ns / 1ps

module pgrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/proportional_glyph_row_renderer.sv @@
// Top level of the proportional glyph row renderer: sequencer, pen register,
// configuration registers and output register. Uses pgrr_pkg and pgrr_ram.
`timescale 1ns / 1ps

// Usage
// An input beat on in_data/in_valid/in_ready carries one command. Loading a
// table entry, loading a glyph byte and setting the pen give no result.
// Render and measure look the character up in the table memory before
// anything is produced, but a glyph code outside the table skips the lookup.
// Measure gives a single result beat after the lookup; an out-of-table code,
// for render or measure, gives a single beat without it. Render gives one beat per
// glyph row; a row needs ceil(width/8) glyph store reads, one per cycle, then
// the last byte is captured and the finished row is handed on to the output.
// Blank and zero-width characters give one row per cycle while the output
// register is free. The single read port of the glyph store sets the row time.
// One command is in flight at a time; in_ready is high only between commands.
// Results leave through a one-entry output register, so a stalled receiver
// holds the sequencer at the next row while the finished one waits.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// are to be made only between commands.
// Synchronous reset clears the pen to zero, restores the register defaults
// and empties the output register. Table and glyph contents are not cleared.

module proportional_glyph_row_renderer
  import pgrr_pkg::*;
#(
  parameter int CHAR_SLOTS = CHAR_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int SLOT_AW = $clog2(CHAR_SLOTS);

  state_t state, state_next;

  logic [5:0] glyph_height;
  logic [7:0] first_code;
  logic [3:0] gap_width;
  logic [5:0] blank_width;
  logic [9:0] pen;

  logic        is_render;
  logic        is_glyph;
  logic [5:0]  cur_width;
  logic [2:0]  bpr;
  logic [GLYPH_AW-1:0] gaddr;
  logic [2:0]  byte_cnt;
  logic        pend;
  logic [1:0]  pend_k;
  logic [31:0] acc;
  logic [4:0]  row;
  logic [4:0]  row_last_idx;
  logic [5:0]  sgl_width;
  logic [9:0]  sgl_pen;
  logic        sgl_status;

  logic        in_accept;
  logic        code_is_glyph;
  logic [7:0]  slot_diff;
  logic        in_table;
  logic        out_free;
  logic        out_load;
  out_item_t   out_next;

  tbl_entry_t  tbl_wdata;
  tbl_entry_t  tbl_rdata;
  logic        tbl_we;
  logic        glyph_we;
  logic [7:0]  glyph_rdata;

  logic [5:0]  eff_blank;
  logic [5:0]  lk_width;
  logic [6:0]  lk_adv;
  logic [10:0] pen_sum;
  logic [9:0]  pen_adv;
  logic [2:0]  lk_bpr;
  logic [5:0]  h_eff;
  logic        glyph_issue;
  logic        row_done;
  logic        row_emit;

  assign in_accept     = in_valid && in_ready;
  assign code_is_glyph = in_data.char_code > SPACE_CODE;
  assign slot_diff     = in_data.char_code - first_code;
  assign in_table      = (in_data.char_code >= first_code) && (32'(slot_diff) < CHAR_SLOTS);
  assign out_free      = !out_valid || out_ready;

  // Table and glyph store writes come straight from the accepted beat.
  assign tbl_we = in_accept && (in_data.func == FN_LOAD_CHAR)
                  && (32'(in_data.table_index) < CHAR_SLOTS);
  assign tbl_wdata.width  = (in_data.entry_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH)
                                                                  : in_data.entry_width;
  assign tbl_wdata.offset = in_data.entry_offset;
  assign glyph_we = in_accept && (in_data.func == FN_LOAD_BYTE);

  pgrr_ram #(
    .WIDTH($bits(tbl_entry_t)),
    .DEPTH(CHAR_SLOTS)
  ) u_char_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(in_data.table_index[SLOT_AW-1:0]),
    .wdata(tbl_wdata),
    .raddr(slot_diff[SLOT_AW-1:0]),
    .rdata(tbl_rdata)
  );

  pgrr_ram #(
    .WIDTH(8),
    .DEPTH(GLYPH_BYTES)
  ) u_glyph_store (
    .clk  (clk),
    .we   (glyph_we),
    .waddr(in_data.table_index[GLYPH_AW-1:0]),
    .wdata(in_data.glyph_byte),
    .raddr(gaddr),
    .rdata(glyph_rdata)
  );

  // Lookup arithmetic, valid in the cycle after the table read was issued.
  assign eff_blank = (blank_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : blank_width;
  assign lk_width  = is_glyph ? tbl_rdata.width : eff_blank;
  assign lk_adv    = 7'(lk_width) + (is_glyph ? 7'(gap_width) : 7'd0);
  assign pen_sum   = 11'(pen) + 11'(lk_adv);
  assign pen_adv   = pen_sum[10] ? PEN_MAX : pen_sum[9:0];
  assign lk_bpr    = is_glyph ? 3'((7'(lk_width) + 7'd7) >> 3) : 3'd0;
  assign h_eff     = (glyph_height == 6'd0) ? 6'd1 :
                     (glyph_height > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : glyph_height;

  assign glyph_issue = (state == ST_ROWS) && (byte_cnt != bpr);
  assign row_done    = (state == ST_ROWS) && (byte_cnt == bpr) && !pend;
  assign row_emit    = row_done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    out_next   = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && ((in_data.func == FN_RENDER) || (in_data.func == FN_MEASURE))) begin
          state_next = (code_is_glyph && !in_table) ? ST_SINGLE : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = is_render ? ST_ROWS : ST_SINGLE;
      end
      ST_ROWS: begin
        if (row_emit) begin
          out_load           = 1'b1;
          out_next.row_bits  = acc & row_mask(cur_width);
          out_next.row_width = cur_width;
          out_next.row_last  = (row == row_last_idx);
          out_next.pen_x     = pen;
          out_next.status    = 1'b0;
          if (row == row_last_idx) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_next.row_bits  = '0;
          out_next.row_width = sgl_width;
          out_next.row_last  = 1'b1;
          out_next.pen_x     = sgl_pen;
          out_next.status    = sgl_status;
          state_next         = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: configuration, pen, pending read and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_height <= 6'd8;
      first_code   <= 8'd33;
      gap_width    <= 4'd1;
      blank_width  <= 6'd4;
      pen          <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GLYPH_HEIGHT: glyph_height <= cfg_data[5:0];
          CFG_FIRST_CODE:   first_code   <= cfg_data;
          CFG_GAP_WIDTH:    gap_width    <= cfg_data[3:0];
          CFG_BLANK_WIDTH:  blank_width  <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_accept && (in_data.func == FN_SET_X)) begin
        pen <= in_data.start_x;
      end else if ((state == ST_LOOKUP) && is_render) begin
        pen <= pen_adv;
      end
      pend <= glyph_issue;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-character working registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      is_render  <= (in_data.func == FN_RENDER);
      is_glyph   <= code_is_glyph;
      sgl_width  <= '0;
      sgl_pen    <= pen;
      sgl_status <= 1'b1;
    end
    if (state == ST_LOOKUP) begin
      cur_width    <= lk_width;
      bpr          <= lk_bpr;
      gaddr        <= tbl_rdata.offset;
      byte_cnt     <= '0;
      acc          <= '0;
      row          <= '0;
      row_last_idx <= 5'(h_eff - 6'd1);
      sgl_width    <= lk_width;
      sgl_pen      <= pen_adv;
      sgl_status   <= 1'b0;
    end
    // Glyph bytes of a row are consecutive in the store, so the address just counts on.
    if (glyph_issue) begin
      gaddr    <= gaddr + GLYPH_AW'(1);
      byte_cnt <= byte_cnt + 3'd1;
      pend_k   <= byte_cnt[1:0];
    end
    if (pend) begin
      acc[{~pend_k, 3'b000} +: 8] <= glyph_rdata;
    end
    if (row_emit) begin
      row      <= row + 5'd1;
      byte_cnt <= '0;
      acc      <= '0;
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // Pixels to the right of the glyph width never leave the block.
  a_row_masked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.row_bits & ~row_mask(out_data.row_width)) == 32'd0))
    else $error("row pixels beyond row width");

  // An out-of-table result is a single empty row.
  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |->
      (out_data.row_last && (out_data.row_width == 6'd0) && (out_data.row_bits == 32'd0)))
    else $error("error beat is not a single empty row");

  // The pen only moves backwards when it is set explicitly.
  a_pen_forward: assert property (@(posedge clk) disable iff (rst)
    !(in_accept && (in_data.func == FN_SET_X)) |=> (pen >= $past(pen)))
    else $error("pen moved backwards");

  // The byte counter never runs past the bytes of one row.
  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROWS) |-> (byte_cnt <= bpr))
    else $error("glyph byte counter overran the row");

endmodule
